/* src/htfd_pkg.sv */
package htfd_pkg;

    localparam logic [7:0]  CrcPoly    = 8'h31;
    localparam logic [7:0]  CrcInit    = 8'hFF;

    localparam int          QueueDepth = 2;

    localparam logic [14:0] TempSpan   = 15'd17500;
    localparam logic [13:0] HumSpan    = 14'd10000;
    localparam logic [15:0] HalfScale  = 16'd32767;
    localparam logic [15:0] TempOffset = 16'd4500;

    localparam int          TempProdW  = 31;
    localparam int          HumProdW   = 30;
    localparam int          TempW      = 15;
    localparam int          HumW       = 14;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [15:0] raw_hum;
        logic        temp_ok;
        logic        hum_ok;
    } t_frame;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ((v << 1) ^ CrcPoly) : (v << 1);
        end
        return v;
    endfunction

endpackage

/* src/htfd_if.sv */
interface htfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, rx_byte, frame_start, input ready);
    modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

interface htfd_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
    logic               temp_check_ok;
    logic               hum_check_ok;
    logic               frame_good;

    modport source (output valid, temp_centi, hum_centi, temp_check_ok, hum_check_ok,
                    frame_good, input ready);
    modport sink (input valid, temp_centi, hum_centi, temp_check_ok, hum_check_ok,
                  frame_good, output ready);
endinterface

/* src/htfd_front.sv */
module htfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    htfd_in_if.sink          i_byte,
    input  logic             i_full,
    output logic             o_push,
    output htfd_pkg::t_frame o_frame
);
    import htfd_pkg::*;

    typedef enum logic [2:0] {
        PosTempHi,
        PosTempLo,
        PosTempCrc,
        PosHumHi,
        PosHumLo,
        PosHumCrc
    } t_pos;

    t_pos        r_pos, n_pos, w_pos;
    logic [7:0]  r_crc, n_crc, w_crc, w_upd;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_hum, n_hum;
    logic        r_tok, n_tok;
    logic        w_acc;

    assign i_byte.ready = !i_full;
    assign w_acc        = i_byte.valid && i_byte.ready;

    always_comb begin
        w_pos  = i_byte.frame_start ? PosTempHi : r_pos;
        w_crc  = i_byte.frame_start ? CrcInit : r_crc;
        w_upd  = crc8_update(w_crc, i_byte.rx_byte);
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_temp = r_temp;
        n_hum  = r_hum;
        n_tok  = r_tok;
        o_push = 1'b0;
        o_frame.raw_temp = r_temp;
        o_frame.raw_hum  = r_hum;
        o_frame.temp_ok  = r_tok;
        o_frame.hum_ok   = (w_crc == i_byte.rx_byte);
        if (w_acc) begin
            unique case (w_pos)
                PosTempHi: begin
                    n_crc  = w_upd;
                    n_temp = {i_byte.rx_byte, r_temp[7:0]};
                    n_pos  = PosTempLo;
                end
                PosTempLo: begin
                    n_crc  = w_upd;
                    n_temp = {r_temp[15:8], i_byte.rx_byte};
                    n_pos  = PosTempCrc;
                end
                PosTempCrc: begin
                    n_tok = (w_crc == i_byte.rx_byte);
                    n_crc = CrcInit;
                    n_pos = PosHumHi;
                end
                PosHumHi: begin
                    n_crc = w_upd;
                    n_hum = {i_byte.rx_byte, r_hum[7:0]};
                    n_pos = PosHumLo;
                end
                PosHumLo: begin
                    n_crc = w_upd;
                    n_hum = {r_hum[15:8], i_byte.rx_byte};
                    n_pos = PosHumCrc;
                end
                default: begin
                    o_push = 1'b1;
                    n_crc  = CrcInit;
                    n_pos  = PosTempHi;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= PosTempHi;
            r_crc <= CrcInit;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_temp <= n_temp;
        r_hum  <= n_hum;
        r_tok  <= n_tok;
    end

endmodule

/* src/htfd_fifo.sv */
module htfd_fifo #(
    parameter int DEPTH = htfd_pkg::QueueDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  htfd_pkg::t_frame i_data,
    output logic             o_full,
    input  logic             i_pop,
    output htfd_pkg::t_frame o_data,
    output logic             o_empty
);
    import htfd_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_frame          r_mem [DEPTH];
    t_frame          r_out;
    logic            r_ov;
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;
    logic            w_mem_empty, w_load, w_bypass, w_inc, w_dec;

    assign w_mem_empty = (r_cnt == '0);
    assign w_load      = !r_ov || i_pop;
    assign w_bypass    = i_push && w_mem_empty && w_load;
    assign w_inc       = i_push && !w_bypass;
    assign w_dec       = w_load && !w_mem_empty;
    assign o_full      = (r_cnt == CntW'(DEPTH));
    assign o_empty     = !r_ov;
    assign o_data      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_load) begin
                r_ov <= i_push || !w_mem_empty;
            end
            if (w_inc) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_dec) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_inc && !w_dec) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_dec && !w_inc) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_inc) begin
            r_mem[r_wr] <= i_data;
        end
        if (w_dec) begin
            r_out <= r_mem[r_rd];
        end else if (w_bypass) begin
            r_out <= i_data;
        end
    end

endmodule

/* src/htfd_back.sv */
module htfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  htfd_pkg::t_frame i_frame,
    output logic             o_pop,
    htfd_out_if.source       o_result
);
    import htfd_pkg::*;

    // Exact floor(x / 65535) for quotients below 65536.
    function automatic logic [15:0] div_full_scale(input logic [31:0] x);
        logic [31:0] s;
        s = x + {16'd0, x[31:16]} + 32'd1;
        return s[31:16];
    endfunction

    logic                 r_v1, r_v2;
    logic [TempProdW-1:0] r_tprod;
    logic [HumProdW-1:0]  r_hprod;
    logic                 r_tok1, r_hok1;
    logic                 w_adv1, w_adv2;
    logic [15:0]          w_tq, w_hq, w_temp;

    assign w_adv2 = !r_v2 || o_result.ready;
    assign w_adv1 = !r_v1 || w_adv2;
    assign o_pop  = !i_empty && w_adv1;

    assign w_tq   = div_full_scale(32'(r_tprod));
    assign w_hq   = div_full_scale(32'(r_hprod));
    assign w_temp = w_tq - TempOffset;

    assign o_result.valid = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= !i_empty;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tprod <= TempProdW'(TempSpan) * TempProdW'(i_frame.raw_temp)
                       + TempProdW'(HalfScale);
            r_hprod <= HumProdW'(HumSpan) * HumProdW'(i_frame.raw_hum)
                       + HumProdW'(HalfScale);
            r_tok1  <= i_frame.temp_ok;
            r_hok1  <= i_frame.hum_ok;
        end
        if (w_adv2 && r_v1) begin
            o_result.temp_centi    <= $signed(w_temp[TempW-1:0]);
            o_result.hum_centi     <= w_hq[HumW-1:0];
            o_result.temp_check_ok <= r_tok1;
            o_result.hum_check_ok  <= r_hok1;
            o_result.frame_good    <= r_tok1 & r_hok1;
        end
    end

endmodule

/* src/humidity_temp_frame_decoder_unit.sv */
// Channel    Dir  Word contents
// i_byte     in   rx_byte, frame_start
// o_result   out  temp_centi, hum_centi, temp_check_ok, hum_check_ok, frame_good
//
// One byte is taken per cycle unless the queue is full; the CRC-8 step and the frame position
// are updated in that cycle. The sixth byte of a frame queues a record, and its result passes
// through the queue, a multiply stage and a reciprocal divide stage into the output register.
// Reset clears the frame position, sets the running CRC to its seed and clears all valid flags.
// A stalled output holds its stages; bytes keep flowing until the queue is full.
module humidity_temp_frame_decoder_unit #(
    parameter int QUEUE_DEPTH = htfd_pkg::QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htfd_in_if.sink    i_byte,
    htfd_out_if.source o_result
);
    import htfd_pkg::*;

    logic   w_push, w_full, w_pop, w_empty;
    t_frame w_frame_in, w_frame_out;

    htfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_frame (w_frame_in)
    );

    htfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_frame_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_frame_out),
        .o_empty (w_empty)
    );

    htfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_frame  (w_frame_out),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

endmodule

/* dv/humidity_temp_frame_decoder_unit_checker.sv */
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_unit_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    htfd_in_if   i_byte_mon,
    htfd_out_if  i_result_mon,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [7:0]  CRC_POLY     = 8'h31;
    localparam logic [7:0]  CRC_SEED     = 8'hFF;
    localparam logic [31:0] TEMP_SPAN    = 32'd17500;
    localparam logic [31:0] HUM_SPAN     = 32'd10000;
    localparam logic [31:0] HALF_SCALE   = 32'd32767;
    localparam logic [31:0] FULL_SCALE   = 32'd65535;
    localparam int          TEMP_OFFSET  = 4500;

    localparam logic [2:0]  POS_TEMP_HI  = 3'd0;
    localparam logic [2:0]  POS_TEMP_LO  = 3'd1;
    localparam logic [2:0]  POS_TEMP_CRC = 3'd2;
    localparam logic [2:0]  POS_HUM_HI   = 3'd3;
    localparam logic [2:0]  POS_HUM_LO   = 3'd4;

    typedef struct packed {
        logic signed [14:0] temp;
        logic [13:0]        hum;
        logic               temp_ok;
        logic               hum_ok;
        logic               good;
    } t_reading;

    t_reading    readings_due[$];
    logic [2:0]  frame_pos;
    logic [7:0]  word_crc;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        temp_crc_ok;
    int          fail_cnt   = 0;
    int          result_idx = 0;

    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] din);
        logic [7:0] r;
        r = acc ^ din;
        repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, result_idx, msg);
        fail_cnt++;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic mark);
        t_reading    r;
        logic [31:0] temp_q;
        logic [31:0] hum_q;
        if (mark) begin
            frame_pos = POS_TEMP_HI;
            word_crc  = CRC_SEED;
        end
        case (frame_pos)
            POS_TEMP_HI: begin
                word_crc        = crc8_step(word_crc, b);
                temp_word[15:8] = b;
                frame_pos       = POS_TEMP_LO;
            end
            POS_TEMP_LO: begin
                word_crc       = crc8_step(word_crc, b);
                temp_word[7:0] = b;
                frame_pos      = POS_TEMP_CRC;
            end
            POS_TEMP_CRC: begin
                temp_crc_ok = (word_crc == b);
                word_crc    = CRC_SEED;
                frame_pos   = POS_HUM_HI;
            end
            POS_HUM_HI: begin
                word_crc       = crc8_step(word_crc, b);
                hum_word[15:8] = b;
                frame_pos      = POS_HUM_LO;
            end
            POS_HUM_LO: begin
                word_crc      = crc8_step(word_crc, b);
                hum_word[7:0] = b;
                frame_pos     = frame_pos + 3'd1;
            end
            default: begin
                temp_q    = (TEMP_SPAN * {16'd0, temp_word} + HALF_SCALE) / FULL_SCALE;
                hum_q     = (HUM_SPAN * {16'd0, hum_word} + HALF_SCALE) / FULL_SCALE;
                r.temp    = 15'(int'(temp_q) - TEMP_OFFSET);
                r.hum     = hum_q[13:0];
                r.temp_ok = temp_crc_ok;
                r.hum_ok  = (word_crc == b);
                r.good    = r.temp_ok & r.hum_ok;
                readings_due.push_back(r);
                word_crc  = CRC_SEED;
                frame_pos = POS_TEMP_HI;
            end
        endcase
    endtask

    task automatic check_reading();
        t_reading want;
        if (readings_due.size() == 0) begin
            report_mismatch("result word with no frame pending");
        end else begin
            want = readings_due.pop_front();
            if (i_result_mon.temp_centi !== want.temp)
                report_mismatch($sformatf("temp_centi %0d, expected %0d",
                                          $signed(i_result_mon.temp_centi), $signed(want.temp)));
            if (i_result_mon.hum_centi !== want.hum)
                report_mismatch($sformatf("hum_centi %0d, expected %0d",
                                          i_result_mon.hum_centi, want.hum));
            if (i_result_mon.temp_check_ok !== want.temp_ok)
                report_mismatch($sformatf("temp_check_ok %b, expected %b",
                                          i_result_mon.temp_check_ok, want.temp_ok));
            if (i_result_mon.hum_check_ok !== want.hum_ok)
                report_mismatch($sformatf("hum_check_ok %b, expected %b",
                                          i_result_mon.hum_check_ok, want.hum_ok));
            if (i_result_mon.frame_good !== want.good)
                report_mismatch($sformatf("frame_good %b, expected %b",
                                          i_result_mon.frame_good, want.good));
        end
        result_idx++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_pos   = POS_TEMP_HI;
            word_crc    = CRC_SEED;
            temp_word   = '0;
            hum_word    = '0;
            temp_crc_ok = 1'b0;
            readings_due.delete();
        end else begin
            if (i_result_mon.valid && i_result_mon.ready) begin
                check_reading();
            end
            if (i_byte_mon.valid && i_byte_mon.ready) begin
                decode_byte(i_byte_mon.rx_byte, i_byte_mon.frame_start);
            end
        end
        o_pending    <= readings_due.size();
        o_fail_count <= fail_cnt;
    end

endmodule

/* dv/humidity_temp_frame_decoder_unit_tb.sv */
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_unit_tb;

    localparam int BYTE_TARGET  = 1250;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_cnt  = 0;
    int   bytes_sent = 0;
    bit   send_burst;
    bit   take_burst;

    htfd_in_if  byte_bus ();
    htfd_out_if result_bus ();

    humidity_temp_frame_decoder_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_bus),
        .o_result (result_bus)
    );

    humidity_temp_frame_decoder_unit_checker decode_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_mon   (byte_bus),
        .i_result_mon (result_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The check byte is built bit-serially, MSB first, so that good frames are truly good.
    function automatic logic [7:0] word_crc(input logic [15:0] w);
        logic [7:0] c;
        c = 8'hFF;
        for (int i = 15; i >= 0; i--) begin
            c = (c[7] ^ w[i]) ? ({c[6:0], 1'b0} ^ 8'h31) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic mark);
        int gap;
        if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            byte_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_bus.valid       <= 1'b1;
        byte_bus.rx_byte     <= b;
        byte_bus.frame_start <= mark;
        do @(posedge i_clk); while (!(byte_bus.valid && byte_bus.ready));
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [15:0] t, input logic [15:0] h, input logic mark,
                              input bit bad_t, input bit bad_h, input int nbytes);
        logic [7:0] fb [6];
        fb[0] = t[15:8];
        fb[1] = t[7:0];
        fb[2] = word_crc(t) ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'h00);
        fb[3] = h[15:8];
        fb[4] = h[7:0];
        fb[5] = word_crc(h) ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'h00);
        for (int i = 0; i < nbytes; i++) begin
            send_byte(fb[i], (i == 0) ? mark : 1'b0);
        end
    endtask

    initial begin
        int kind;
        int n;
        bit need_mark;
        byte_bus.valid       <= 1'b0;
        byte_bus.rx_byte     <= '0;
        byte_bus.frame_start <= 1'b0;
        i_rst_n              <= 1'b0;
        send_burst = 1'($urandom_range(0, 1));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0, 6);
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 6);
        send_frame(16'h1234, 16'h5678, 1'b1, 1'b0, 1'b0, 3);
        send_frame(16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b0, 6);
        send_frame(16'h00FF, 16'hFF00, 1'b0, 1'b0, 1'b1, 6);

        // Most traffic is whole frames; cut frames and loose bytes force a marked restart.
        need_mark = 1'b0;
        while (bytes_sent < BYTE_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                send_frame(pick_word(), pick_word(), need_mark || ($urandom_range(0, 1) == 1),
                           $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0, 6);
                need_mark = 1'b0;
            end else if (kind == 7) begin
                send_frame(pick_word(), pick_word(), 1'($urandom_range(0, 1)), 1'b0, 1'b0,
                           $urandom_range(1, 5));
                need_mark = 1'b1;
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                need_mark = 1'b1;
            end
        end
        byte_bus.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        int stall;
        result_bus.ready <= 1'b0;
        take_burst = 1'($urandom_range(0, 1));
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
            stall = take_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(result_bus.valid && result_bus.ready));
        end
    end

endmodule
